// ===== design/frame_or_deadline_progress_timer_core_macros.svh =====
// Assertion macros used by the timer core controller.
// Each use names a label, an antecedent and a consequent; the clock is
// i_clk and the synchronous reset i_rst_n of the module that uses it.
`ifndef FRAME_OR_DEADLINE_PROGRESS_TIMER_CORE_MACROS_SVH
`define FRAME_OR_DEADLINE_PROGRESS_TIMER_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define FDPT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer core assertion failed");

// Consequent holds in the cycle after the antecedent.
`define FDPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer core assertion failed");

`endif

// ===== design/fdpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer core package
// Shared constants, op codes and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package fdpt_pkg;

    // FULL_SCALE is a power of two, 2**FULL_SHIFT
    localparam int          FULL_SHIFT = 16;
    localparam logic [31:0] FULL_SCALE = 32'd1 << FULL_SHIFT;
    localparam int          DIV_STEPS  = 64;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_SCALE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_STEP = 2'd1,
        ST_BAD_RATIO = 2'd2,
        ST_NEG_TOTAL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        MUL_FLIP,
        MUL_TICK,
        MUL_SC_STEP,
        MUL_SC_END,
        MUL_SC_TOT
    } t_mul_sel;

    typedef enum logic [2:0] {
        DIV_FRAMES,
        DIV_REM,
        DIV_TICK,
        DIV_SC_DEN,
        DIV_SC_NUM
    } t_div_sel;

    typedef enum logic [3:0] {
        CM_NONE,
        CM_LOAD,
        CM_STEP_Q,
        CM_F_START,
        CM_F_ZERO,
        CM_D_START,
        CM_TICK_F,
        CM_TICK_D0,
        CM_TICK_D,
        CM_SC_BAD,
        CM_SC_STEP,
        CM_SC_Q1,
        CM_SC_DL,
        CM_NOP
    } t_commit;

    typedef struct packed {
        t_commit  commit;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        t_div_sel div_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic deadline_mode;
        logic dur_pos;
        logic step_zero;
        logic ratio_bad;
        logic tick_live;
        logic div_done;
    } t_dp_status;

endpackage

// ===== design/fdpt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer core divider
// Signed 64-by-33 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdpt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    import fdpt_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_q;
    logic [32:0]      r_r;
    logic [32:0]      r_dvs;
    logic             r_qneg;
    logic             r_rneg;

    logic [33:0] shifted;
    logic [34:0] diff;
    logic        ge;
    logic [63:0] q_fix;
    logic [32:0] r_fix;

    assign shifted = {r_r, r_q[63]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign ge      = !diff[34];
    assign q_fix   = r_qneg ? (64'd0 - r_q) : r_q;
    assign r_fix   = r_rneg ? (33'd0 - r_r) : r_r;
    assign o_quo   = q_fix[31:0];
    assign o_rem   = r_fix[31:0];
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Operand magnitudes load on start; shift one bit per busy cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend[63] ? (64'd0 - i_dividend) : i_dividend;
            r_r    <= '0;
            r_dvs  <= i_divisor[32] ? (33'd0 - i_divisor) : i_divisor;
            r_qneg <= i_dividend[63] ^ i_divisor[32];
            r_rneg <= i_dividend[63];
        end else if (r_busy) begin
            r_q <= {r_q[62:0], ge};
            r_r <= ge ? diff[32:0] : shifted[32:0];
        end
    end

endmodule

// ===== design/fdpt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer core datapath
// Input and timer state registers, shared multiplier, divider, result words.
// ----------------------------------------------------------------------------
module fdpt_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fdpt_pkg::t_dp_cmd      i_cmd,
    output fdpt_pkg::t_dp_status   o_stat,
    input  logic [1:0]             i_op,
    input  logic signed [31:0]     i_duration,
    input  logic                   i_count_up,
    input  logic                   i_preserve,
    input  logic [31:0]            i_now_ms,
    input  logic [31:0]            i_numerator,
    input  logic [31:0]            i_denominator,
    output logic [31:0]            o_progress,
    output logic [1:0]             o_status
);
    import fdpt_pkg::*;

    // latched input word
    t_op         r_op;
    logic [31:0] r_dur;
    logic        r_up;
    logic        r_keep;
    logic [31:0] r_now;
    logic [31:0] r_num;
    logic [31:0] r_den;

    // timer state
    logic        r_deadline;
    logic        r_rising;
    logic [31:0] r_left;
    logic [31:0] r_step;
    logic [31:0] r_total;
    logic [31:0] r_end;

    logic [63:0] r_prod;
    logic [31:0] r_q1;
    logic [31:0] r_res_prog;
    t_status     r_res_stat;
    logic [31:0] r_out_prog;
    t_status     r_out_stat;

    logic               flip;
    logic [31:0]        remaining;
    logic [31:0]        frames;
    logic [31:0]        togo;
    logic [31:0]        tick_rem;
    logic [31:0]        tick_rem_c;
    logic [31:0]        flip_sum;
    logic [31:0]        flip_quo;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        div_dd;
    logic [32:0]        div_dv;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [31:0]        div_rem;

    assign flip       = r_keep && (r_rising != r_up);
    assign remaining  = flip ? (FULL_SCALE - r_left) : FULL_SCALE;
    assign frames     = 32'd1 - r_dur;
    assign togo       = r_end - r_now;
    assign tick_rem   = r_left - r_step;
    assign tick_rem_c = tick_rem[31] ? 32'd0 : tick_rem;

    // signed product over FULL_SCALE, truncated toward zero: bias negatives
    assign flip_sum = r_prod[31:0] + (r_prod[31] ? (FULL_SCALE - 32'd1) : 32'd0);
    assign flip_quo = $signed(flip_sum) >>> FULL_SHIFT;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_FLIP: begin
                mul_a = {1'b0, r_left};
                mul_b = {1'b0, r_dur};
            end
            MUL_TICK: begin
                mul_a = {1'b0, togo};
                mul_b = {1'b0, FULL_SCALE};
            end
            MUL_SC_STEP: begin
                mul_a = {r_step[31], r_step};
                mul_b = {1'b0, r_num};
            end
            MUL_SC_END: begin
                mul_a = {togo[31], togo};
                mul_b = {1'b0, r_den};
            end
            MUL_SC_TOT: begin
                mul_a = {r_total[31], r_total};
                mul_b = {1'b0, r_den};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_FRAMES: begin
                div_dd = {32'd0, FULL_SCALE};
                div_dv = {frames[31], frames};
            end
            DIV_REM: begin
                div_dd = {{32{remaining[31]}}, remaining};
                div_dv = {1'b0, r_q1};
            end
            DIV_TICK: begin
                div_dd = {{32{r_prod[31]}}, r_prod[31:0]};
                div_dv = {r_total[31], r_total};
            end
            DIV_SC_DEN: begin
                div_dd = r_prod;
                div_dv = {1'b0, r_den};
            end
            DIV_SC_NUM: begin
                div_dd = r_prod;
                div_dv = {1'b0, r_num};
            end
            default: begin
                div_dd = '0;
                div_dv = 33'd1;
            end
        endcase
    end

    fdpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dd),
        .i_divisor  (div_dv),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // timer state: commit only on a successful event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= 1'b0;
            r_rising   <= 1'b0;
            r_left     <= '0;
            r_step     <= '0;
            r_total    <= '0;
            r_end      <= '0;
        end else begin
            case (i_cmd.commit)
                CM_F_START: begin
                    r_step     <= r_q1;
                    r_left     <= remaining - div_rem;
                    r_deadline <= 1'b0;
                    r_rising   <= r_up;
                end
                CM_D_START: begin
                    r_total    <= r_dur;
                    r_end      <= r_now + r_dur - (flip ? flip_quo : 32'd0);
                    r_deadline <= 1'b1;
                    r_rising   <= r_up;
                end
                CM_TICK_F:  r_left <= tick_rem_c;
                CM_TICK_D0: r_left <= '0;
                CM_TICK_D:  r_left <= div_quo;
                CM_SC_STEP: r_step <= div_quo;
                CM_SC_DL: begin
                    if (!div_quo[31]) begin
                        r_end   <= r_now + r_q1;
                        r_total <= div_quo;
                    end
                end
                default: ;
            endcase
        end
    end

    // input word, product, partial quotient and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit == CM_LOAD) begin
            r_op   <= t_op'(i_op);
            r_dur  <= i_duration;
            r_up   <= i_count_up;
            r_keep <= i_preserve;
            r_now  <= i_now_ms;
            r_num  <= i_numerator;
            r_den  <= i_denominator;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.commit == CM_STEP_Q || i_cmd.commit == CM_SC_Q1) begin
            r_q1 <= div_quo;
        end
        case (i_cmd.commit)
            CM_F_ZERO: begin
                r_res_prog <= '0;
                r_res_stat <= ST_ZERO_STEP;
            end
            CM_SC_BAD: begin
                r_res_prog <= '0;
                r_res_stat <= ST_BAD_RATIO;
            end
            CM_TICK_F: begin
                r_res_prog <= r_rising ? (FULL_SCALE - tick_rem_c) : tick_rem_c;
                r_res_stat <= ST_OK;
            end
            CM_TICK_D0: begin
                r_res_prog <= r_rising ? FULL_SCALE : 32'd0;
                r_res_stat <= ST_OK;
            end
            CM_TICK_D: begin
                r_res_prog <= r_rising ? (FULL_SCALE - div_quo) : div_quo;
                r_res_stat <= ST_OK;
            end
            CM_SC_DL: begin
                r_res_prog <= '0;
                r_res_stat <= div_quo[31] ? ST_NEG_TOTAL : ST_OK;
            end
            CM_F_START, CM_D_START, CM_SC_STEP, CM_NOP: begin
                r_res_prog <= '0;
                r_res_stat <= ST_OK;
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out_prog <= r_res_prog;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_progress = r_out_prog;
    assign o_status   = r_out_stat;

    assign o_stat.op            = r_op;
    assign o_stat.deadline_mode = r_deadline;
    assign o_stat.dur_pos       = !r_dur[31] && (r_dur != 32'd0);
    assign o_stat.step_zero     = (r_q1 == 32'd0);
    assign o_stat.ratio_bad     = (r_num == 32'd0) || (r_den == 32'd0);
    assign o_stat.tick_live     = (r_total != 32'd0) && (r_now <= r_end);
    assign o_stat.div_done      = div_done;

endmodule

// ===== design/fdpt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer core controller
// Sequences one event through decode, multiply and divide steps.
// ----------------------------------------------------------------------------
module fdpt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  fdpt_pkg::t_dp_status i_stat,
    output fdpt_pkg::t_dp_cmd    o_cmd
);
    import fdpt_pkg::*;

    `include "frame_or_deadline_progress_timer_core_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_F_DIV1,
        S_F_CHK,
        S_F_DIV2,
        S_D_ADJ,
        S_T_DIV,
        S_S_DIV1,
        S_S_DIV2,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_go;
    logic   n_go;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_div;

    assign in_div = (r_state == S_F_DIV1) || (r_state == S_F_DIV2) ||
                    (r_state == S_T_DIV)  ||
                    (r_state == S_S_DIV1) || (r_state == S_S_DIV2);

    always_comb begin
        n_state       = r_state;
        n_go          = 1'b0;
        o_cmd         = '0;
        o_cmd.commit  = CM_NONE;
        o_cmd.mul_sel = MUL_FLIP;
        o_cmd.div_sel = DIV_FRAMES;
        o_cmd.div_start = r_go;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.commit = CM_LOAD;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_START: begin
                        if (i_stat.dur_pos) begin
                            o_cmd.mul_en  = 1'b1;
                            o_cmd.mul_sel = MUL_FLIP;
                            n_state       = S_D_ADJ;
                        end else begin
                            n_go    = 1'b1;
                            n_state = S_F_DIV1;
                        end
                    end
                    OP_TICK: begin
                        if (!i_stat.deadline_mode) begin
                            o_cmd.commit = CM_TICK_F;
                            n_state      = S_FINISH;
                        end else if (i_stat.tick_live) begin
                            o_cmd.mul_en  = 1'b1;
                            o_cmd.mul_sel = MUL_TICK;
                            n_go          = 1'b1;
                            n_state       = S_T_DIV;
                        end else begin
                            o_cmd.commit = CM_TICK_D0;
                            n_state      = S_FINISH;
                        end
                    end
                    OP_SCALE: begin
                        if (i_stat.ratio_bad) begin
                            o_cmd.commit = CM_SC_BAD;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.mul_en  = 1'b1;
                            o_cmd.mul_sel = i_stat.deadline_mode ? MUL_SC_END : MUL_SC_STEP;
                            n_go          = 1'b1;
                            n_state       = S_S_DIV1;
                        end
                    end
                    default: begin
                        o_cmd.commit = CM_NOP;
                        n_state      = S_FINISH;
                    end
                endcase
            end
            S_F_DIV1: begin
                o_cmd.div_sel = DIV_FRAMES;
                if (i_stat.div_done) begin
                    o_cmd.commit = CM_STEP_Q;
                    n_state      = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_stat.step_zero) begin
                    o_cmd.commit = CM_F_ZERO;
                    n_state      = S_FINISH;
                end else begin
                    n_go    = 1'b1;
                    n_state = S_F_DIV2;
                end
            end
            S_F_DIV2: begin
                o_cmd.div_sel = DIV_REM;
                if (i_stat.div_done) begin
                    o_cmd.commit = CM_F_START;
                    n_state      = S_FINISH;
                end
            end
            S_D_ADJ: begin
                // product is ready; the flip shift is combinational
                o_cmd.commit = CM_D_START;
                n_state      = S_FINISH;
            end
            S_T_DIV: begin
                o_cmd.div_sel = DIV_TICK;
                if (i_stat.div_done) begin
                    o_cmd.commit = CM_TICK_D;
                    n_state      = S_FINISH;
                end
            end
            S_S_DIV1: begin
                o_cmd.div_sel = i_stat.deadline_mode ? DIV_SC_NUM : DIV_SC_DEN;
                if (i_stat.div_done) begin
                    if (i_stat.deadline_mode) begin
                        // hold the scaled time-to-go, then scale the total
                        o_cmd.commit  = CM_SC_Q1;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_SC_TOT;
                        n_go          = 1'b1;
                        n_state       = S_S_DIV2;
                    end else begin
                        o_cmd.commit = CM_SC_STEP;
                        n_state      = S_FINISH;
                    end
                end
            end
            S_S_DIV2: begin
                o_cmd.div_sel = DIV_SC_NUM;
                if (i_stat.div_done) begin
                    o_cmd.commit = CM_SC_DL;
                    n_state      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    `FDPT_ASSERT_SAME(a_go_in_div, r_go, in_div)
    `FDPT_ASSERT_SAME(a_done_in_div, i_stat.div_done, in_div && !r_go)
    `FDPT_ASSERT_NEXT(a_load_sets_valid, o_cmd.out_load, r_out_valid && (r_state == S_IDLE))

endmodule

// ===== design/frame_or_deadline_progress_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame or deadline progress timer core
// Start, tick and speed-scale events on a two-mode progress timer.
// ----------------------------------------------------------------------------
// One event is taken at a time and gives exactly one result word. A
// frame-mode tick, a deadline tick past its end, a bad ratio and the unused
// op code go through load, decode and hand-off; a deadline start also does
// its direction-flip correction, a multiply and a shift. The rest use the
// shared signed divider, which resolves one quotient bit per cycle: a live
// deadline tick and a frame-mode scale use one division; a deadline-mode
// scale uses two; a frame-mode start uses two or stops after the first with
// a zero step. A zero frame step, a bad ratio or a negative scaled total
// return a nonzero status and leave the timer state untouched. The result
// word sits in an output register, so the next event is taken while the last
// result still waits to be read; an event whose result is ready holds until
// that register is free.
module frame_or_deadline_progress_timer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_duration,
    input  logic               i_count_up,
    input  logic               i_preserve,
    input  logic [31:0]        i_now_ms,
    input  logic [31:0]        i_numerator,
    input  logic [31:0]        i_denominator,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_progress,
    output logic [1:0]         o_status
);
    import fdpt_pkg::*;

    // command and status between the sequencer and the arithmetic
    t_dp_cmd    cmd;
    t_dp_status stat;

    fdpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fdpt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_duration    (i_duration),
        .i_count_up    (i_count_up),
        .i_preserve    (i_preserve),
        .i_now_ms      (i_now_ms),
        .i_numerator   (i_numerator),
        .i_denominator (i_denominator),
        .o_progress    (o_progress),
        .o_status      (o_status)
    );

endmodule
